/* rtl/core/acat_pkg.sv */
// ----------------------------------------------------------------------------
// acat_pkg
// Shared types and codes for the card allow table: beat field widths,
// action codes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package acat_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 64;

  localparam int CARD_ID_W   = 64;
  localparam int ACTION_W    = 2;
  localparam int ENTRY_CNT_W = 5;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  typedef enum logic [1:0] {
    OK_ZERO,
    OK_ONE,
    OK_HIT_EN
  } ok_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd;
    logic    rd_next;
    logic    idx_inc;
    logic    wr_upd;
    logic    wr_app;
    logic    wr_shift;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    ok_load;
    ok_sel_t ok_sel;
    logic    out_load;
  } acat_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic                hit;
    logic                empty;
    logic                search_last;
    logic                shift_last;
    logic                out_free;
  } acat_sts_t;

endpackage

`default_nettype wire

/* rtl/core/access_card_allow_table_core.sv */
// ----------------------------------------------------------------------------
// access_card_allow_table_core
// Ordered allow table of card identifiers with lookup, add, remove and clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel carries one request beat: in_tuser is the action (lookup,
//   add/update, remove, clear) and in_tdata the card id and enable flag.
//   out_* channel returns exactly one result beat per request: ok and the
//   entry count after the operation.
//   One request is in flight at a time; in_tready is high only while the
//   controller is idle. Entries are compared one per cycle from the single
//   read port of the entry memory. A remove that copies entries down does a
//   read then a write for each copy, the first read overlapping the matching
//   compare. Clear and requests on an empty table compare no entries. The
//   longest request at depth D is a remove of the first of D entries.
//   Reset clears the entry count and the result valid; the entry memory is
//   not cleared, unused entries are never read.
//   If the receiver stalls, the result stays in the output register; one
//   more request is accepted and worked through, then waits in the
//   controller with in_tready low until the held beat has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module access_card_allow_table_core
  import acat_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [63:0] card_id, [64] enable_flag, [71:65] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  wire logic [ACTION_W-1:0]    in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] ok, [5:1] entry_count, [7:6] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  acat_cmd_t              cmd;
  acat_sts_t              sts;
  logic                   res_ok;
  logic [ENTRY_CNT_W-1:0] res_cnt;

  acat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  acat_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_tuser),
    .in_card_id      (in_tdata[CARD_ID_W-1:0]),
    .in_enable_flag  (in_tdata[CARD_ID_W]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_ok          (res_ok),
    .out_entry_count (res_cnt)
  );

  assign out_tdata = {(OUT_TDATA_W - ENTRY_CNT_W - 1)'(0), res_cnt, res_ok};

endmodule

`default_nettype wire

/* rtl/core/acat_ctrl.sv */
// ----------------------------------------------------------------------------
// acat_ctrl
// Sequencer for the allow table: walks the entries one per cycle for the
// search, then copies entries down, a read and a write each, for a remove.
// ----------------------------------------------------------------------------
`default_nettype none

module acat_ctrl
  import acat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire acat_sts_t sts,
  output acat_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_SHRD = 3'd3;
  localparam logic [2:0] S_SHWR = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.ok_sel = OK_ZERO;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.ok_load = 1'b1;
        if (sts.act == ACT_CLEAR) begin
          cmd.cnt_clr = 1'b1;
          cmd.ok_sel  = OK_ONE;
          state_nxt   = S_FIN;
        end else if (sts.empty) begin
          if (sts.act == ACT_ADD) begin
            cmd.wr_app = 1'b1;
            cmd.ok_sel = OK_ONE;
          end
          state_nxt = S_FIN;
        end else begin
          cmd.ok_load = 1'b0;
          cmd.rd      = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.ok_load = 1'b1;
          priority case (sts.act)
            ACT_LOOKUP: begin
              cmd.ok_sel = OK_HIT_EN;
              state_nxt  = S_FIN;
            end
            ACT_ADD: begin
              cmd.wr_upd = 1'b1;
              cmd.ok_sel = OK_ONE;
              state_nxt  = S_FIN;
            end
            default: begin
              // remove: close the gap left by the matching entry
              cmd.ok_sel = OK_ONE;
              if (sts.search_last) begin
                cmd.cnt_dec = 1'b1;
                state_nxt   = S_FIN;
              end else begin
                cmd.rd      = 1'b1;
                cmd.rd_next = 1'b1;
                state_nxt   = S_SHWR;
              end
            end
          endcase
        end else if (sts.search_last) begin
          cmd.ok_load = 1'b1;
          if (sts.act == ACT_ADD) begin
            cmd.wr_app = 1'b1;
            cmd.ok_sel = OK_ONE;
          end
          state_nxt = S_FIN;
        end else begin
          cmd.rd      = 1'b1;
          cmd.rd_next = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHRD: begin
        cmd.rd      = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt   = S_SHWR;
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.shift_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/acat_dpath.sv */
// ----------------------------------------------------------------------------
// acat_dpath
// Datapath for the allow table: entry memory, entry count, walk index,
// captured request and the registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module acat_dpath
  import acat_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire acat_cmd_t              cmd,
  output acat_sts_t                   sts,
  input  wire logic [ACTION_W-1:0]    in_action,
  input  wire logic [CARD_ID_W-1:0]   in_card_id,
  input  wire logic                   in_enable_flag,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_ok,
  output logic [ENTRY_CNT_W-1:0]      out_entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = ID_BITS + 1;

  // entry layout: enable flag on top of the identifier
  logic [EW-1:0]       mem [TABLE_DEPTH];
  logic [EW-1:0]       rdata_r;

  logic [ACTION_W-1:0] act_r;
  logic [ID_BITS-1:0]  key_r;
  logic                en_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                ok_r, ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r;
  logic [ENTRY_CNT_W-1:0] out_cnt_r;

  logic                full;
  logic [AW-1:0]       app_addr;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;

  assign full     = (cnt_r == CW'(TABLE_DEPTH));
  assign app_addr = full ? AW'(TABLE_DEPTH - 1) : cnt_r[AW-1:0];
  assign rd_addr  = cmd.rd_next ? AW'(idx_r + CW'(1)) : idx_r[AW-1:0];
  assign wr_en    = cmd.wr_upd | cmd.wr_app | cmd.wr_shift;
  assign wr_addr  = cmd.wr_app ? app_addr : idx_r[AW-1:0];
  assign wr_data  = cmd.wr_shift ? rdata_r : {en_r, key_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.wr_app) begin
      cnt_nxt = full ? cnt_r : cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end

    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end

    ok_nxt = ok_r;
    if (cmd.ok_load) begin
      unique case (cmd.ok_sel)
        OK_ZERO:   ok_nxt = 1'b0;
        OK_ONE:    ok_nxt = 1'b1;
        OK_HIT_EN: ok_nxt = rdata_r[ID_BITS];
        default:   ok_nxt = 1'b0;
      endcase
    end

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ok_r  <= ok_nxt;
    if (cmd.load) begin
      act_r <= in_action;
      key_r <= in_card_id[ID_BITS-1:0];
      en_r  <= in_enable_flag;
    end
    if (cmd.out_load) begin
      out_ok_r  <= ok_r;
      out_cnt_r <= ENTRY_CNT_W'(cnt_r);
    end
  end

  assign sts.act         = act_r;
  assign sts.hit         = (rdata_r[ID_BITS-1:0] == key_r);
  assign sts.empty       = (cnt_r == '0);
  assign sts.search_last = ({1'b0, idx_r} + (CW+1)'(1)) >= {1'b0, cnt_r};
  assign sts.shift_last  = ({1'b0, idx_r} + (CW+1)'(2)) >= {1'b0, cnt_r};
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_entry_count = out_cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_clr |=> cnt_r == '0)
    else $error("clear did not empty the table");

  a_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> cnt_r != '0)
    else $error("remove on an empty table");

  a_app: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_app && !full) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("append did not grow the count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* tb/tb_access_card_allow_table_core.sv */
// ----------------------------------------------------------------------------
// tb_access_card_allow_table_core
// Self-checking bench for the card allow table. A directed table of requests
// covers the empty table, updates, disabled cards, ordered removal and clear.
// A long random run follows, drawing cards from a small pool so that matches,
// misses and full-table overwrites all happen often. Every accepted request
// goes through an in-bench model of the table. Every result beat is compared
// with the oldest outstanding expected result. Both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_access_card_allow_table_core
  import acat_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = 16;
  localparam int ID_BITS        = 64;
  localparam int POOL_SIZE      = 24;
  localparam int RANDOM_OPS     = 1430;
  localparam int CALM_OPS       = 150;
  localparam int HOLD_AT        = 100;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 3 * TABLE_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic [CARD_ID_W-1:0] ID_MASK =
    (ID_BITS >= CARD_ID_W) ? '1 : ((64'd1 << ID_BITS) - 64'd1);
  localparam logic [CARD_ID_W-1:0] ID_ONES = '1;
  localparam logic [CARD_ID_W-1:0] ID_MSB  = 64'h8000_0000_0000_0000;
  localparam logic [CARD_ID_W-1:0] ID_ALT0 = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [CARD_ID_W-1:0] ID_ALT1 = 64'h5555_5555_5555_5555;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CARD_ID_W-1:0] card_id;
    logic                 enable;
  } card_req_t;

  typedef struct packed {
    logic                   ok;
    logic [ENTRY_CNT_W-1:0] count;
  } card_resp_t;

  typedef struct packed {
    card_req_t  req;
    logic       fixed;
    card_resp_t res;
  } directed_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [ACTION_W-1:0]    in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // table contents as the bench believes them to be
  logic [CARD_ID_W-1:0] card_ids [TABLE_DEPTH];
  logic                 card_en  [TABLE_DEPTH];
  int                   card_count;

  card_resp_t    pending_results[$];
  directed_row_t directed_ops[$];
  logic [CARD_ID_W-1:0] id_pool [POOL_SIZE];

  int   mismatches  = 0;
  int   idle_cycles = 0;
  logic calm        = 1'b0;
  logic hold_req    = 1'b0;

  access_card_allow_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // applies one request to the table image and returns the answer it gives
  function automatic card_resp_t predict_card_op(card_req_t r);
    card_resp_t           res;
    logic [CARD_ID_W-1:0] key;
    int                   hit;
    key = r.card_id & ID_MASK;
    hit = -1;
    res.ok = 1'b0;
    for (int i = 0; i < card_count; i++) begin
      if (hit < 0 && card_ids[i] == key) hit = i;
    end
    case (r.action)
      ACT_LOOKUP: begin
        res.ok = (hit >= 0) && card_en[hit];
      end
      ACT_ADD: begin
        if (hit >= 0) begin
          card_en[hit] = r.enable;
        end else begin
          // full table: the last entry gives way to the new card
          if (card_count >= TABLE_DEPTH) card_count = TABLE_DEPTH - 1;
          card_ids[card_count] = key;
          card_en[card_count]  = r.enable;
          card_count++;
        end
        res.ok = 1'b1;
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          for (int j = hit; j + 1 < card_count; j++) begin
            card_ids[j] = card_ids[j + 1];
            card_en[j]  = card_en[j + 1];
          end
          card_count--;
          res.ok = 1'b1;
        end
      end
      default: begin
        card_count = 0;
        res.ok = 1'b1;
      end
    endcase
    res.count = card_count[ENTRY_CNT_W-1:0];
    return res;
  endfunction

  task automatic add_row(input logic [ACTION_W-1:0] action, input logic [CARD_ID_W-1:0] id,
                         input int en, input int fixed, input int ok,
                         input int cnt);
    directed_row_t row;
    row.req.action  = action;
    row.req.card_id = id;
    row.req.enable  = en[0];
    row.fixed       = fixed[0];
    row.res.ok      = ok[0];
    row.res.count   = cnt[ENTRY_CNT_W-1:0];
    directed_ops.push_back(row);
  endtask

  task automatic send_card_op(input card_req_t r, input logic fixed, input card_resp_t typed);
    card_resp_t predicted;
    int         gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.action;
    in_tdata  <= {7'd0, r.enable, r.card_id};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predicted = predict_card_op(r);
    pending_results.push_back(fixed ? typed : predicted);
  endtask

  // mostly pool cards so the table fills and overflows; a few fully random beats
  function automatic card_req_t pick_card_op();
    card_req_t r;
    int        roll;
    roll = $urandom_range(0, 99);
    r.enable = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 19) == 0) begin
      r.action  = ACTION_W'($urandom_range(0, 3));
      r.card_id = {$urandom, $urandom};
    end else begin
      if (roll < 30)      r.action = ACT_LOOKUP;
      else if (roll < 66) r.action = ACT_ADD;
      else if (roll < 97) r.action = ACT_REMOVE;
      else                r.action = ACT_CLEAR;
      r.card_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return r;
  endfunction

  // stimulus
  initial begin
    card_req_t  r;
    card_resp_t none;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= ACT_LOOKUP;
    card_count = 0;
    none       = '0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = '0;
    id_pool[1] = ID_ONES;
    id_pool[2] = ID_MSB;

    //      action      card_id  en  typed ok  cnt
    add_row(ACT_LOOKUP, '0,      1,  1,    0,  0);
    add_row(ACT_REMOVE, ID_ONES, 0,  1,    0,  0);
    add_row(ACT_CLEAR,  '0,      0,  1,    1,  0);
    add_row(ACT_ADD,    '0,      1,  1,    1,  1);
    add_row(ACT_ADD,    ID_ONES, 0,  1,    1,  2);
    add_row(ACT_LOOKUP, '0,      0,  1,    1,  2);
    add_row(ACT_LOOKUP, ID_ONES, 1,  1,    0,  2);
    add_row(ACT_ADD,    ID_ONES, 1,  1,    1,  2);
    add_row(ACT_LOOKUP, ID_ONES, 0,  0,    0,  0);
    add_row(ACT_ADD,    '0,      0,  1,    1,  2);
    add_row(ACT_LOOKUP, '0,      1,  0,    0,  0);
    add_row(ACT_LOOKUP, ID_MSB,  0,  1,    0,  2);
    add_row(ACT_ADD,    ID_MSB,  1,  0,    0,  0);
    add_row(ACT_ADD,    ID_ALT0, 1,  0,    0,  0);
    add_row(ACT_ADD,    ID_ALT1, 0,  0,    0,  0);
    add_row(ACT_REMOVE, '0,      1,  1,    1,  4);
    add_row(ACT_LOOKUP, ID_ALT1, 0,  0,    0,  0);
    add_row(ACT_REMOVE, ID_ALT0, 0,  0,    0,  0);
    add_row(ACT_REMOVE, ID_ALT0, 0,  1,    0,  3);
    add_row(ACT_LOOKUP, ID_MSB,  0,  0,    0,  0);
    add_row(ACT_CLEAR,  ID_ALT1, 1,  1,    1,  0);
    // stale entries must stay invisible after clear
    add_row(ACT_LOOKUP, ID_ONES, 0,  1,    0,  0);
    add_row(ACT_REMOVE, ID_ALT1, 0,  1,    0,  0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[k]) begin
      send_card_op(directed_ops[k].req, directed_ops[k].fixed, directed_ops[k].res);
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == RANDOM_OPS - CALM_OPS) calm = 1'b1;
      if ($urandom_range(0, 49) == 0) id_pool[$urandom_range(3, POOL_SIZE - 1)] = {$urandom, $urandom};
      r = pick_card_op();
      send_card_op(r, 1'b0, none);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side: check each beat, then pick next cycle's ready
  initial begin
    card_resp_t want;
    logic       hold_done;
    int         stall_left;
    hold_done  = 1'b0;
    stall_left = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing expected, got ok=%0b count=%0d",
                   $time, out_tdata[0], out_tdata[5:1]);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[0] !== want.ok) begin
            mismatches++;
            $display("%0t: ok mismatch, expected %0b actual %0b", $time, want.ok, out_tdata[0]);
          end
          if (out_tdata[5:1] !== want.count) begin
            mismatches++;
            $display("%0t: entry_count mismatch, expected %0d actual %0d",
                     $time, want.count, out_tdata[5:1]);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        // long hold-off so the block backs up and drops in_tready
        hold_done  = 1'b1;
        stall_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
